@@ rtl/qrf_pkg.sv @@
`timescale 1ns / 1ps
package qrf_pkg;

	localparam int MAX_MESSAGE = 4096;

	// Byte count saturates one above the largest message, so it must hold MAX_MESSAGE + 1.
	localparam int POS_W = $clog2(MAX_MESSAGE + 2);
	localparam int OFF_W = ($clog2(MAX_MESSAGE) > 12) ? $clog2(MAX_MESSAGE) : 12;
	localparam int SUM_W = 17;

	localparam logic ACT_BEGIN = 1'b0;
	localparam logic ACT_BYTE  = 1'b1;

	localparam logic [1:0] V_ACCEPT  = 2'd0;
	localparam logic [1:0] V_DISCARD = 2'd1;
	localparam logic [1:0] V_PROTO   = 2'd2;

	localparam logic [1:0] RS_SUCCESS = 2'd0;
	localparam logic [1:0] RS_REFUSED = 2'd1;
	localparam logic [1:0] RS_ABSENT  = 2'd2;

	localparam logic [7:0] QMUX_MARKER = 8'h01;
	localparam logic [7:0] QMUX_FLAGS  = 8'h80;
	localparam logic [7:0] CTL_FLAGS   = 8'h01;
	localparam logic [7:0] SVC_FLAGS   = 8'h02;
	localparam logic [7:0] RESULT_TLV  = 8'h02;
	localparam logic [7:0] CTL_SERVICE = 8'h00;

	localparam logic [3:0] HDR_LEN_CTL = 4'd12;
	localparam logic [3:0] HDR_LEN_SVC = 4'd13;
	localparam int HDR_BYTES = 13;

	typedef struct packed {
		logic        action;
		logic [7:0]  data_byte;
		logic        last;
		logic [7:0]  expect_service;
		logic [7:0]  expect_client;
		logic [15:0] expect_message;
		logic [15:0] expect_transaction;
		logic [7:0]  want_first;
		logic [7:0]  want_second;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [11:0] payload_length;
		logic [1:0]  result_state;
		logic [15:0] error_code;
		logic        first_found;
		logic [11:0] first_offset;
		logic [11:0] first_length;
		logic        second_found;
		logic [11:0] second_offset;
		logic [11:0] second_length;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  service;
		logic [7:0]  client;
		logic [15:0] message;
		logic [15:0] transaction;
	} expect_t;

	typedef struct packed {
		logic        id_ok;
		logic [15:0] qmux_len;
		logic [15:0] tlv_len;
	} hdr_status_t;

	typedef struct packed {
		logic             well;
		logic             res_ok;
		logic [15:0]      res_status;
		logic [15:0]      res_code;
		logic             first_hit;
		logic [OFF_W-1:0] first_off;
		logic [11:0]      first_len;
		logic             second_hit;
		logic [OFF_W-1:0] second_off;
		logic [11:0]      second_len;
	} walk_status_t;

endpackage

@@ rtl/qrf_in_if.sv @@
`timescale 1ns / 1ps
interface qrf_in_if;
	import qrf_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/qrf_out_if.sv @@
`timescale 1ns / 1ps
interface qrf_out_if;
	import qrf_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/qrf_header.sv @@
`timescale 1ns / 1ps
module qrf_header
	import qrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear,
	input  logic        we,
	input  logic [3:0]  wr_pos,
	input  logic [7:0]  wr_byte,
	input  expect_t     expect_id,
	output hdr_status_t status
);

	logic [7:0] hdr_q [HDR_BYTES];
	logic [7:0] hdr_n [HDR_BYTES];
	logic       ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HDR_BYTES; i++) hdr_q[i] <= '0;
		end else if (clear) begin
			for (int i = 0; i < HDR_BYTES; i++) hdr_q[i] <= '0;
		end else if (we) begin
			for (int i = 0; i < HDR_BYTES; i++) begin
				if (wr_pos == 4'(i)) hdr_q[i] <= wr_byte;
			end
		end
	end

	// The checks look at the header including a byte written in this cycle.
	always_comb begin
		for (int i = 0; i < HDR_BYTES; i++) begin
			hdr_n[i] = (we && wr_pos == 4'(i)) ? wr_byte : hdr_q[i];
		end
	end

	assign ctl = (expect_id.service == CTL_SERVICE);

	always_comb begin
		status.qmux_len = {hdr_n[2], hdr_n[1]};
		status.id_ok = hdr_n[0] == QMUX_MARKER && hdr_n[3] == QMUX_FLAGS &&
			hdr_n[4] == expect_id.service && hdr_n[5] == expect_id.client;
		if (ctl) begin
			status.tlv_len = {hdr_n[11], hdr_n[10]};
			status.id_ok = status.id_ok && hdr_n[6] == CTL_FLAGS &&
				{hdr_n[9], hdr_n[8]} == expect_id.message &&
				hdr_n[7] == expect_id.transaction[7:0];
		end else begin
			status.tlv_len = {hdr_n[12], hdr_n[11]};
			status.id_ok = status.id_ok && hdr_n[6] == SVC_FLAGS &&
				{hdr_n[10], hdr_n[9]} == expect_id.message &&
				{hdr_n[8], hdr_n[7]} == expect_id.transaction;
		end
	end

endmodule

@@ rtl/qrf_tlv_walk.sv @@
`timescale 1ns / 1ps
module qrf_tlv_walk
	import qrf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         clear,
	input  logic         en,
	input  logic [7:0]   in_byte,
	input  logic [7:0]   want_first,
	input  logic [7:0]   want_second,
	output walk_status_t status
);

	localparam logic [1:0] PH_TYPE   = 2'd0;
	localparam logic [1:0] PH_LEN_LO = 2'd1;
	localparam logic [1:0] PH_LEN_HI = 2'd2;
	localparam logic [1:0] PH_VALUE  = 2'd3;

	logic [1:0]       phase_q, phase_n;
	logic [15:0]      len_q, len_n;
	logic [15:0]      rem_q, rem_n;
	logic [OFF_W-1:0] off_q, off_n;
	logic [7:0]       type_q, type_n;
	logic             cap_q, cap_n;
	logic [2:0]       cidx_q, cidx_n;
	logic [7:0]       rv_q [4];
	logic [7:0]       rv_n [4];
	logic [1:0]       cnt_q [3];
	logic [1:0]       cnt_n [3];
	logic [OFF_W-1:0] moff_q [2];
	logic [OFF_W-1:0] moff_n [2];
	logic [11:0]      mlen_q [2];
	logic [11:0]      mlen_n [2];
	logic             rlen4_q, rlen4_n;
	logic [7:0]       want [2];

	assign want[0] = want_first;
	assign want[1] = want_second;

	always_comb begin
		phase_n = phase_q;
		len_n   = len_q;
		rem_n   = rem_q;
		off_n   = off_q;
		type_n  = type_q;
		cap_n   = cap_q;
		cidx_n  = cidx_q;
		rlen4_n = rlen4_q;
		for (int i = 0; i < 4; i++) rv_n[i] = rv_q[i];
		for (int i = 0; i < 3; i++) cnt_n[i] = cnt_q[i];
		for (int i = 0; i < 2; i++) begin
			moff_n[i] = moff_q[i];
			mlen_n[i] = mlen_q[i];
		end
		if (en) begin
			off_n = off_q + OFF_W'(1);
			unique case (phase_q)
				PH_TYPE: begin
					type_n  = in_byte;
					phase_n = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_n   = {8'h00, in_byte};
					phase_n = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_n  = {in_byte, len_q[7:0]};
					cap_n  = 1'b0;
					cidx_n = '0;
					for (int k = 0; k < 2; k++) begin
						if (type_q == want[k]) begin
							if (cnt_q[k] == 2'd0) begin
								moff_n[k] = off_q + OFF_W'(1);
								mlen_n[k] = len_n[11:0];
							end
							if (cnt_q[k] != 2'd2) cnt_n[k] = cnt_q[k] + 2'd1;
						end
					end
					// Only the first result TLV is captured; a second one voids it anyway.
					if (type_q == RESULT_TLV) begin
						cap_n = (cnt_q[2] == 2'd0);
						if (cnt_q[2] == 2'd0) rlen4_n = (len_n == 16'd4);
						if (cnt_q[2] != 2'd2) cnt_n[2] = cnt_q[2] + 2'd1;
					end
					rem_n   = len_n;
					phase_n = (len_n != 16'd0) ? PH_VALUE : PH_TYPE;
				end
				PH_VALUE: begin
					if (cap_q && !cidx_q[2]) rv_n[cidx_q[1:0]] = in_byte;
					if (!cidx_q[2]) cidx_n = cidx_q + 3'd1;
					rem_n = rem_q - 16'd1;
					if (rem_n == 16'd0) phase_n = PH_TYPE;
				end
				default: phase_n = PH_TYPE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			len_q   <= '0;
			rem_q   <= '0;
			off_q   <= '0;
			type_q  <= '0;
			cap_q   <= 1'b0;
			cidx_q  <= '0;
			rlen4_q <= 1'b0;
			for (int i = 0; i < 4; i++) rv_q[i] <= '0;
			for (int i = 0; i < 3; i++) cnt_q[i] <= '0;
			for (int i = 0; i < 2; i++) begin
				moff_q[i] <= '0;
				mlen_q[i] <= '0;
			end
		end else if (clear) begin
			phase_q <= PH_TYPE;
			len_q   <= '0;
			rem_q   <= '0;
			off_q   <= '0;
			type_q  <= '0;
			cap_q   <= 1'b0;
			cidx_q  <= '0;
			rlen4_q <= 1'b0;
			for (int i = 0; i < 4; i++) rv_q[i] <= '0;
			for (int i = 0; i < 3; i++) cnt_q[i] <= '0;
			for (int i = 0; i < 2; i++) begin
				moff_q[i] <= '0;
				mlen_q[i] <= '0;
			end
		end else begin
			phase_q <= phase_n;
			len_q   <= len_n;
			rem_q   <= rem_n;
			off_q   <= off_n;
			type_q  <= type_n;
			cap_q   <= cap_n;
			cidx_q  <= cidx_n;
			rlen4_q <= rlen4_n;
			for (int i = 0; i < 4; i++) rv_q[i] <= rv_n[i];
			for (int i = 0; i < 3; i++) cnt_q[i] <= cnt_n[i];
			for (int i = 0; i < 2; i++) begin
				moff_q[i] <= moff_n[i];
				mlen_q[i] <= mlen_n[i];
			end
		end
	end

	always_comb begin
		status.well       = (phase_n == PH_TYPE);
		status.res_ok     = (cnt_n[2] == 2'd1) && rlen4_n;
		status.res_status = {rv_n[1], rv_n[0]};
		status.res_code   = {rv_n[3], rv_n[2]};
		status.first_hit  = (cnt_n[0] == 2'd1);
		status.first_off  = moff_n[0];
		status.first_len  = mlen_n[0];
		status.second_hit = (cnt_n[1] == 2'd1);
		status.second_off = moff_n[1];
		status.second_len = mlen_n[1];
	end

endmodule

@@ rtl/qmi_response_filter_tlv_locator.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Word                                           | Handshake
// item    | in  | begin (expectations) or one message byte       | valid / ready
// result  | out | verdict, result TLV and two TLV places         | valid / ready
//
// Each word is held in the input register and is folded into the message
// state when it leaves it, so a word may be accepted in every cycle while the input does not stall.
// A result is registered once the word with last has passed the input register and been folded in.
// Reset clears the expectations and all per-message state.
// The input stalls only when the result register is full and not being taken.
module qmi_response_filter_tlv_locator
	import qrf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	qrf_in_if.sink     item,
	qrf_out_if.source  result
);

	logic         v_s1;
	in_item_t     item_s1;
	logic         out_valid_q;
	out_item_t    out_data_q, out_n;
	expect_t      exp_q;
	logic [7:0]   want0_q, want1_q;
	logic [POS_W-1:0] pos_q, pos_n;
	logic         adv, proc, is_byte, step, in_hdr, clr;
	logic [3:0]   hlen;
	hdr_status_t  hdr;
	walk_status_t walk;
	logic         id_ok;

	assign adv        = !out_valid_q || result.ready;
	assign item.ready = !v_s1 || adv;
	assign proc       = v_s1 && adv;
	assign is_byte    = (item_s1.action == ACT_BYTE);
	assign hlen       = (exp_q.service == CTL_SERVICE) ? HDR_LEN_CTL : HDR_LEN_SVC;
	assign step       = (pos_q <= POS_W'(MAX_MESSAGE));
	assign in_hdr     = (pos_q < POS_W'(hlen));
	assign pos_n      = (proc && is_byte && step) ? pos_q + POS_W'(1) : pos_q;
	assign clr        = proc && (!is_byte || item_s1.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) item_s1 <= item.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q   <= '0;
			want0_q <= '0;
			want1_q <= '0;
		end else if (proc && !is_byte) begin
			exp_q.service     <= item_s1.expect_service;
			exp_q.client      <= item_s1.expect_client;
			exp_q.message     <= item_s1.expect_message;
			exp_q.transaction <= item_s1.expect_transaction;
			want0_q           <= item_s1.want_first;
			want1_q           <= item_s1.want_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (clr) begin
			pos_q <= '0;
		end else begin
			pos_q <= pos_n;
		end
	end

	qrf_header u_header (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clr),
		.we        (proc && is_byte && step && in_hdr),
		.wr_pos    (pos_q[3:0]),
		.wr_byte   (item_s1.data_byte),
		.expect_id (exp_q),
		.status    (hdr)
	);

	qrf_tlv_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (clr),
		.en          (proc && is_byte && step && !in_hdr),
		.in_byte     (item_s1.data_byte),
		.want_first  (want0_q),
		.want_second (want1_q),
		.status      (walk)
	);

	assign id_ok = (pos_n >= POS_W'(hlen)) && hdr.id_ok;

	always_comb begin
		out_n = '0;
		if (!id_ok) begin
			out_n.verdict = V_DISCARD;
		end else if (pos_n > POS_W'(MAX_MESSAGE)) begin
			out_n.verdict = V_PROTO;
		end else if (SUM_W'(hdr.qmux_len) + SUM_W'(1) != SUM_W'(pos_n) ||
				SUM_W'(hlen) + SUM_W'(hdr.tlv_len) != SUM_W'(pos_n)) begin
			out_n.verdict = V_PROTO;
		end else begin
			out_n.verdict        = V_ACCEPT;
			out_n.payload_length = hdr.tlv_len[11:0];
			if (walk.well && walk.res_ok) begin
				out_n.result_state = (walk.res_status == 16'd0) ? RS_SUCCESS : RS_REFUSED;
				out_n.error_code   = walk.res_code;
			end else begin
				out_n.result_state = RS_ABSENT;
			end
			if (walk.well && walk.first_hit) begin
				out_n.first_found  = 1'b1;
				out_n.first_offset = walk.first_off[11:0];
				out_n.first_length = walk.first_len;
			end
			if (walk.well && walk.second_hit) begin
				out_n.second_found  = 1'b1;
				out_n.second_offset = walk.second_off[11:0];
				out_n.second_length = walk.second_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && is_byte && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && is_byte && item_s1.last) out_data_q <= out_n;
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

endmodule

@@ sim/qmi_response_filter_tlv_locator_tb.sv @@
`timescale 1ns / 1ps
module qmi_response_filter_tlv_locator_tb;
	import qrf_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_WORDS = 1950;
	localparam int HOLD_CYCLES = 250;

	typedef enum logic [1:0] {WALK_TYPE, WALK_LEN_LO, WALK_LEN_HI, WALK_VALUE} walk_phase_t;

	logic clk;
	logic arst_n;

	qrf_in_if item_ch ();
	qrf_out_if result_ch ();

	qmi_response_filter_tlv_locator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	in_item_t pending_words[$];
	out_item_t expected_answers[$];
	out_item_t predicted;
	int unsigned total_words;
	int unsigned words_taken;
	int unsigned answers_seen;
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned hold_left;
	bit hold_done;

	// Stimulus building: the identity of the answer being composed.
	logic [7:0] id_service, id_client;
	logic [15:0] id_message, id_transaction;
	logic [7:0] id_want [2];
	logic [7:0] tlv_body[$];
	logic [7:0] frame_bytes[$];

	// Filter state mirrored by the predictor.
	expect_t awaited;
	logic [7:0] want_type [2];
	int unsigned seen_bytes;
	logic [7:0] hdr [HDR_BYTES];
	walk_phase_t walk_phase;
	logic [15:0] walk_len;
	logic [7:0] walk_tlv_type;
	int unsigned walk_left, walk_off, capture_idx;
	bit capturing;
	logic [7:0] result_bytes [4];
	int unsigned hit_count [3];
	logic [31:0] hit_off [3];
	logic [15:0] hit_len [3];

	function automatic void forget_message();
		seen_bytes = 0;
		foreach (hdr[i]) hdr[i] = '0;
		walk_phase = WALK_TYPE;
		walk_len = '0;
		walk_tlv_type = '0;
		walk_left = 0;
		walk_off = 0;
		capture_idx = 0;
		capturing = 1'b0;
		foreach (result_bytes[i]) result_bytes[i] = '0;
		foreach (hit_count[i]) begin
			hit_count[i] = 0;
			hit_off[i] = '0;
			hit_len[i] = '0;
		end
	endfunction

	function automatic void note_hit(int slot, logic [31:0] start);
		if (hit_count[slot] == 0) begin
			hit_off[slot] = start;
			hit_len[slot] = walk_len;
		end
		if (hit_count[slot] < 2) hit_count[slot]++;
	endfunction

	function automatic void walk_payload(logic [7:0] b);
		case (walk_phase)
			WALK_TYPE: begin
				walk_tlv_type = b;
				walk_phase = WALK_LEN_LO;
			end
			WALK_LEN_LO: begin
				walk_len = {8'h00, b};
				walk_phase = WALK_LEN_HI;
			end
			WALK_LEN_HI: begin
				walk_len[15:8] = b;
				capturing = 1'b0;
				capture_idx = 0;
				if (walk_tlv_type == want_type[0]) note_hit(0, walk_off + 1);
				if (walk_tlv_type == want_type[1]) note_hit(1, walk_off + 1);
				if (walk_tlv_type == RESULT_TLV) begin
					// Only the first result TLV supplies status and code.
					capturing = (hit_count[2] == 0);
					note_hit(2, walk_off + 1);
				end
				walk_left = 32'(walk_len);
				walk_phase = (walk_len != 0) ? WALK_VALUE : WALK_TYPE;
			end
			default: begin
				if (capturing && capture_idx < 4) result_bytes[capture_idx] = b;
				capture_idx++;
				walk_left--;
				if (walk_left == 0) walk_phase = WALK_TYPE;
			end
		endcase
		walk_off++;
	endfunction

	function automatic logic [15:0] hdr16(int unsigned at);
		return {hdr[at + 1], hdr[at]};
	endfunction

	// Returns 1 when the word produces an answer, which is then placed in r.
	function automatic bit filter_word(input in_item_t w, output out_item_t r);
		int unsigned hlen, count, qmux_len, tlv_len;
		logic [15:0] status;
		bit id_ok, well;
		r = '0;
		if (w.action == ACT_BEGIN) begin
			awaited.service = w.expect_service;
			awaited.client = w.expect_client;
			awaited.message = w.expect_message;
			awaited.transaction = w.expect_transaction;
			want_type[0] = w.want_first;
			want_type[1] = w.want_second;
			forget_message();
			return 1'b0;
		end
		hlen = (awaited.service == CTL_SERVICE) ? 32'(HDR_LEN_CTL) : 32'(HDR_LEN_SVC);
		if (seen_bytes <= MAX_MESSAGE) begin
			if (seen_bytes < hlen) hdr[seen_bytes] = w.data_byte;
			else walk_payload(w.data_byte);
			seen_bytes++;
		end
		if (!w.last) return 1'b0;

		count = seen_bytes;
		id_ok = count >= hlen && hdr[0] == QMUX_MARKER && hdr[3] == QMUX_FLAGS &&
			hdr[4] == awaited.service && hdr[5] == awaited.client &&
			hdr[6] == ((awaited.service == CTL_SERVICE) ? CTL_FLAGS : SVC_FLAGS) &&
			hdr16(hlen - 4) == awaited.message;
		if (id_ok) begin
			if (awaited.service == CTL_SERVICE) id_ok = hdr[7] == awaited.transaction[7:0];
			else id_ok = hdr16(7) == awaited.transaction;
		end

		if (!id_ok) begin
			r.verdict = V_DISCARD;
		end else if (count > MAX_MESSAGE) begin
			r.verdict = V_PROTO;
		end else begin
			qmux_len = 32'(hdr16(1));
			tlv_len = 32'(hdr16(hlen - 2));
			if (qmux_len + 1 != count || hlen + tlv_len != count) begin
				r.verdict = V_PROTO;
			end else begin
				well = (walk_phase == WALK_TYPE);
				r.verdict = V_ACCEPT;
				r.payload_length = tlv_len[11:0];
				if (well && hit_count[2] == 1 && hit_len[2] == 16'd4) begin
					status = {result_bytes[1], result_bytes[0]};
					r.result_state = (status == 16'h0000) ? RS_SUCCESS : RS_REFUSED;
					r.error_code = {result_bytes[3], result_bytes[2]};
				end else begin
					r.result_state = RS_ABSENT;
				end
				if (well && hit_count[0] == 1) begin
					r.first_found = 1'b1;
					r.first_offset = hit_off[0][11:0];
					r.first_length = hit_len[0][11:0];
				end
				if (well && hit_count[1] == 1) begin
					r.second_found = 1'b1;
					r.second_offset = hit_off[1][11:0];
					r.second_length = hit_len[1][11:0];
				end
			end
		end
		forget_message();
		return 1'b1;
	endfunction

	task automatic queue_begin(logic [7:0] svc, logic [7:0] client, logic [15:0] msg,
			logic [15:0] txn, logic [7:0] wa, logic [7:0] wb);
		in_item_t w;
		id_service = svc;
		id_client = client;
		id_message = msg;
		id_transaction = txn;
		id_want[0] = wa;
		id_want[1] = wb;
		w.action = ACT_BEGIN;
		w.data_byte = 8'($urandom);
		w.last = 1'($urandom);
		w.expect_service = svc;
		w.expect_client = client;
		w.expect_message = msg;
		w.expect_transaction = txn;
		w.want_first = wa;
		w.want_second = wb;
		pending_words.push_back(w);
	endtask

	task automatic add_tlv(logic [7:0] kind, int unsigned len);
		logic [15:0] l16;
		l16 = 16'(len);
		tlv_body.push_back(kind);
		tlv_body.push_back(l16[7:0]);
		tlv_body.push_back(l16[15:8]);
		repeat (len) tlv_body.push_back(8'($urandom));
	endtask

	task automatic add_result(logic [15:0] status, logic [15:0] code);
		tlv_body.push_back(RESULT_TLV);
		tlv_body.push_back(8'd4);
		tlv_body.push_back(8'd0);
		tlv_body.push_back(status[7:0]);
		tlv_body.push_back(status[15:8]);
		tlv_body.push_back(code[7:0]);
		tlv_body.push_back(code[15:8]);
	endtask

	// Wraps the collected TLVs in a QMUX header that matches the current identity.
	task automatic frame_answer();
		int unsigned hlen;
		logic [15:0] qlen, blen;
		hlen = (id_service == CTL_SERVICE) ? 32'(HDR_LEN_CTL) : 32'(HDR_LEN_SVC);
		blen = 16'(tlv_body.size());
		qlen = 16'(hlen + tlv_body.size() - 1);
		frame_bytes.delete();
		frame_bytes.push_back(QMUX_MARKER);
		frame_bytes.push_back(qlen[7:0]);
		frame_bytes.push_back(qlen[15:8]);
		frame_bytes.push_back(QMUX_FLAGS);
		frame_bytes.push_back(id_service);
		frame_bytes.push_back(id_client);
		frame_bytes.push_back((id_service == CTL_SERVICE) ? CTL_FLAGS : SVC_FLAGS);
		frame_bytes.push_back(id_transaction[7:0]);
		if (id_service != CTL_SERVICE) frame_bytes.push_back(id_transaction[15:8]);
		frame_bytes.push_back(id_message[7:0]);
		frame_bytes.push_back(id_message[15:8]);
		frame_bytes.push_back(blen[7:0]);
		frame_bytes.push_back(blen[15:8]);
		foreach (tlv_body[i]) frame_bytes.push_back(tlv_body[i]);
		tlv_body.delete();
	endtask

	task automatic queue_frame(int unsigned count, bit close);
		in_item_t w;
		for (int unsigned i = 0; i < count; i++) begin
			w.action = ACT_BYTE;
			w.data_byte = frame_bytes[i];
			w.last = close && (i == count - 1);
			w.expect_service = 8'($urandom);
			w.expect_client = 8'($urandom);
			w.expect_message = 16'($urandom);
			w.expect_transaction = 16'($urandom);
			w.want_first = 8'($urandom);
			w.want_second = 8'($urandom);
			pending_words.push_back(w);
		end
	endtask

	function automatic logic [7:0] pick_type();
		if ($urandom_range(3) == 0) return RESULT_TLV;
		return 8'($urandom);
	endfunction

	function automatic int unsigned tlv_size();
		if ($urandom_range(9) == 0) return $urandom_range(300);
		return $urandom_range(6);
	endfunction

	task automatic random_exchange();
		logic [7:0] svc, wa, wb, flip;
		int unsigned hlen, cut, idx;
		svc = 8'($urandom_range(255, 1));
		if ($urandom_range(9) < 4) svc = CTL_SERVICE;
		wa = pick_type();
		wb = ($urandom_range(7) == 0) ? wa : pick_type();
		if ($urandom_range(9) != 0)
			queue_begin(svc, 8'($urandom), 16'($urandom), 16'($urandom), wa, wb);

		repeat ($urandom_range(5)) begin
			case ($urandom_range(5)) inside
				0: add_tlv(id_want[0], tlv_size());
				1: add_tlv(id_want[1], tlv_size());
				[2:3]: begin
					if ($urandom_range(3) == 0) add_tlv(RESULT_TLV, tlv_size());
					else add_result(($urandom_range(1) != 0) ? 16'($urandom) : 16'h0000,
						16'($urandom));
				end
				default: add_tlv(pick_type(), tlv_size());
			endcase
		end
		case ($urandom_range(19))
			0: repeat ($urandom_range(2, 1)) tlv_body.push_back(8'($urandom));
			1: begin
				// A value that runs past the end of the message.
				cut = $urandom_range(8, 2);
				tlv_body.push_back(pick_type());
				tlv_body.push_back(cut[7:0]);
				tlv_body.push_back(8'h00);
				repeat ($urandom_range(cut - 1)) tlv_body.push_back(8'($urandom));
			end
			default: ;
		endcase
		frame_answer();

		hlen = (id_service == CTL_SERVICE) ? 32'(HDR_LEN_CTL) : 32'(HDR_LEN_SVC);
		cut = frame_bytes.size();
		flip = 8'h01 << $urandom_range(7);
		case ($urandom_range(19)) inside
			[0:1]: begin
				idx = $urandom_range(hlen - 1);
				frame_bytes[idx] = frame_bytes[idx] ^ flip;
			end
			2: cut = $urandom_range(frame_bytes.size() - 1, 1);
			3: frame_bytes[1] = frame_bytes[1] ^ flip;
			4: frame_bytes[hlen - 2] = frame_bytes[hlen - 2] ^ flip;
			default: ;
		endcase
		if ($urandom_range(24) == 0) begin
			// Abandon the message part way and start over with the same expectations.
			queue_frame($urandom_range(cut, 1), 1'b0);
			queue_begin(id_service, id_client, id_message, id_transaction, id_want[0],
				id_want[1]);
		end
		queue_frame(cut, 1'b1);
	endtask

	function automatic int unsigned idle_share(bit receiver);
		if (words_taken < total_words / 3) return receiver ? 69 : 19;
		if (words_taken < 2 * total_words / 3) return receiver ? 19 : 69;
		return 0;
	endfunction

	task automatic check_answer(out_item_t got);
		out_item_t want;
		if (expected_answers.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("answer %0d not expected: got %p", answers_seen, got);
		end else begin
			want = expected_answers.pop_front();
			if (got.verdict !== want.verdict || got.payload_length !== want.payload_length ||
					got.result_state !== want.result_state ||
					got.error_code !== want.error_code ||
					got.first_found !== want.first_found ||
					got.first_offset !== want.first_offset ||
					got.first_length !== want.first_length ||
					got.second_found !== want.second_found ||
					got.second_offset !== want.second_offset ||
					got.second_length !== want.second_length) begin
				mismatches++;
				if (mismatches <= 10)
					$display("answer %0d: expected %p, got %p", answers_seen, want, got);
			end
		end
		answers_seen++;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		fork
			forever #5 clk = ~clk;
			begin
				repeat (2) @(posedge clk);
				@(negedge clk);
				arst_n = 1'b1;
			end
		join
	end

	// Driver: offers queued words; each accepted word goes through the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.data <= '0;
			words_taken <= 0;
			awaited = '0;
			want_type[0] = '0;
			want_type[1] = '0;
			forget_message();
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				if (filter_word(item_ch.data, predicted)) expected_answers.push_back(predicted);
				words_taken <= words_taken + 1;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= idle_share(1'b0)) begin
					item_ch.data <= pending_words.pop_front();
					item_ch.valid <= 1'b1;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// One long hold-off on the result side while words keep coming. It starts in
	// the short random messages with a result waiting, so the input soon stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && total_words != 0 && result_ch.valid &&
				words_taken >= total_words - RANDOM_WORDS / 2) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) check_answer(result_ch.data);
			result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_share(1'b1));
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int unsigned directed_words;
		total_words = 0;
		id_service = CTL_SERVICE;
		id_client = '0;
		id_message = '0;
		id_transaction = '0;
		id_want[0] = '0;
		id_want[1] = '0;

		// Bytes before any begin are judged against the cleared expectations, and a
		// second answer needs no new begin because the expectations are kept.
		add_tlv(8'h00, 2);
		add_result(16'h0000, 16'h0000);
		frame_answer();
		queue_frame(frame_bytes.size(), 1'b1);
		queue_frame(frame_bytes.size(), 1'b1);

		queue_begin(CTL_SERVICE, 8'hFF, 16'hFFFF, 16'hFFAB, 8'h10, 8'h11);
		add_result(16'h0000, 16'h0000);
		add_tlv(8'h10, 3);
		add_tlv(8'h11, 0);
		frame_answer();
		queue_frame(frame_bytes.size(), 1'b1);

		queue_begin(8'hFF, 8'h01, 16'h0001, 16'hFFFF, 8'hFF, RESULT_TLV);
		add_tlv(8'hFF, 1);
		add_result(16'h8001, 16'hBEEF);
		frame_answer();
		queue_frame(frame_bytes.size(), 1'b1);

		// Repeated types count as absent.
		queue_begin(8'h07, 8'h03, 16'h0123, 16'h8001, 8'h10, 8'h20);
		add_tlv(8'h10, 1);
		add_result(16'h0000, 16'h0005);
		add_tlv(8'h10, 2);
		add_result(16'h0000, 16'h0000);
		add_tlv(8'h20, 4);
		frame_answer();
		queue_frame(frame_bytes.size(), 1'b1);

		queue_begin(CTL_SERVICE, 8'h40, 16'h0022, 16'h0007, RESULT_TLV, 8'h21);
		add_tlv(RESULT_TLV, 3);
		add_tlv(8'h21, 1);
		frame_answer();
		queue_frame(frame_bytes.size(), 1'b1);

		add_result(16'h0000, 16'h0000);
		tlv_body.push_back(8'h5A);
		frame_answer();
		queue_frame(frame_bytes.size(), 1'b1);

		add_tlv(8'h21, 2);
		tlv_body.push_back(8'h30);
		tlv_body.push_back(8'h09);
		tlv_body.push_back(8'h00);
		tlv_body.push_back(8'hAA);
		frame_answer();
		queue_frame(frame_bytes.size(), 1'b1);

		add_result(16'h0000, 16'h0000);
		frame_answer();
		queue_frame(5, 1'b1);

		// Header faults, one per message: marker, QMUX flags, message flags, client,
		// transaction, QMUX length and TLV length.
		queue_begin(8'h05, 8'h09, 16'h1234, 16'h5678, 8'h10, 8'h11);
		for (int k = 0; k < 7; k++) begin
			add_result(16'h0000, 16'h0000);
			frame_answer();
			case (k)
				0: frame_bytes[0] = 8'h02;
				1: frame_bytes[3] = 8'h00;
				2: frame_bytes[6] = CTL_FLAGS;
				3: frame_bytes[5] = frame_bytes[5] ^ 8'h01;
				4: frame_bytes[8] = frame_bytes[8] ^ 8'h80;
				5: frame_bytes[1] = frame_bytes[1] ^ 8'h01;
				default: frame_bytes[11] = frame_bytes[11] ^ 8'h01;
			endcase
			queue_frame(frame_bytes.size(), 1'b1);
		end

		frame_answer();
		queue_frame(frame_bytes.size(), 1'b1);

		// Largest message, then over-size ones with matching and foreign identity.
		queue_begin(CTL_SERVICE, 8'h02, 16'h00AA, 16'h0055, 8'h33, 8'h34);
		add_tlv(8'h33, MAX_MESSAGE - 15);
		frame_answer();
		queue_frame(frame_bytes.size(), 1'b1);
		add_tlv(8'h33, MAX_MESSAGE - 6);
		frame_answer();
		queue_frame(frame_bytes.size(), 1'b1);
		add_tlv(8'h33, MAX_MESSAGE - 6);
		frame_answer();
		frame_bytes[5] = frame_bytes[5] ^ 8'h01;
		queue_frame(frame_bytes.size(), 1'b1);

		add_result(16'h0000, 16'h0000);
		add_tlv(8'h33, 2);
		frame_answer();
		queue_frame(6, 1'b0);
		queue_begin(CTL_SERVICE, 8'h02, 16'h00AA, 16'h0055, 8'h34, 8'h33);
		queue_frame(frame_bytes.size(), 1'b1);

		directed_words = pending_words.size();
		while (pending_words.size() < directed_words + RANDOM_WORDS) random_exchange();
		total_words = pending_words.size();

		@(posedge clk);
		while (pending_words.size() != 0 || item_ch.valid) @(posedge clk);
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/qrf_pkg.sv
rtl/qrf_in_if.sv
rtl/qrf_out_if.sv
rtl/qrf_header.sv
rtl/qrf_tlv_walk.sv
rtl/qmi_response_filter_tlv_locator.sv
sim/qmi_response_filter_tlv_locator_tb.sv
